// ===== rtl/maze_flood_fill_solver_top_defines.svh =====
`ifndef MAZE_FLOOD_FILL_SOLVER_TOP_DEFINES_SVH
`define MAZE_FLOOD_FILL_SOLVER_TOP_DEFINES_SVH

// clocked assertion, held off during reset
`define MFFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds while reset is low
`define MFFS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mffs_pkg.sv =====
package mffs_pkg;

    // op codes
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_WALL   = 3'd1;
    localparam logic [2:0] OP_FLOOD  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_WRDIST = 3'd4;
    localparam logic [2:0] OP_BEST   = 3'd5;

    // sides
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // register indexes
    localparam logic [1:0] REG_GOAL_ROW_LO = 2'd0;
    localparam logic [1:0] REG_GOAL_ROW_HI = 2'd1;
    localparam logic [1:0] REG_GOAL_COL_LO = 2'd2;
    localparam logic [1:0] REG_GOAL_COL_HI = 2'd3;

    localparam logic [7:0] DIST_NONE = 8'hFF;
    localparam logic [3:0] WALL_ALL  = 4'hF;
    localparam logic [3:0] WALL_N    = 4'h1;
    localparam logic [3:0] WALL_E    = 4'h2;
    localparam logic [3:0] WALL_S    = 4'h4;
    localparam logic [3:0] WALL_W    = 4'h8;

    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 16;
    localparam int OUT_DONE_BIT = 14;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_INIT,
        S_WCELL,
        S_WNB,
        S_RCELL,
        S_BCHK,
        S_BNB,
        S_BCMP,
        S_FCLR,
        S_SEED,
        S_POP,
        S_CELL,
        S_CHK,
        S_NB,
        S_UPD,
        S_DONE
    } state_t;

endpackage

// ===== rtl/maze_flood_fill_solver_top.sv =====
// channel   dir  signals                         transfer
// s_*       in   s_tvalid s_tready s_tuser s_tdata  one op
// m_*       out  m_tvalid m_tready m_tdata          one result per op
// cfg_*     in   cfg_wr_en cfg_addr cfg_wdata       one goal register
//
// init: one sweep step per cell on the wall and distance rams
// flood: a clear sweep of the distance ram, then the seed cells, then each reached cell, paced by the
// single read port of the distance ram (one neighbour read, then compare and write)
// after reset a clearing pass over every cell runs, s_tready stays low
// the result register frees the input side: the next op is taken while a result waits
module maze_flood_fill_solver_top #(
    parameter int GRID_SIDE   = 16,
    parameter int QUEUE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // op
    // row[3:0] column[7:4] direction[9:8] present[10] toward_goal[11] distance_in[19:12]
    input  logic [mffs_pkg::IN_DATA_W-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // distance_out[7:0] wall_mask[11:8] best_direction[13:12] done_res[14]
    output logic [mffs_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [3:0]  cfg_wdata
);

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int CW     = (CELLS > 2) ? $clog2(CELLS) : 1;
    localparam int QW     = $clog2(QUEUE_DEPTH);
    localparam int FW     = $clog2(QUEUE_DEPTH + 1);
    localparam logic [4:0] SIDE5 = 5'(GRID_SIDE);
    localparam logic [3:0] LAST  = 4'(GRID_SIDE - 1);
    localparam logic [QW-1:0] QLAST = QW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] QFULL = FW'(QUEUE_DEPTH);

    function automatic logic [CW-1:0] cell_idx(input logic [3:0] r, input logic [3:0] c);
        return CW'(32'(r) * GRID_SIDE + 32'(c));
    endfunction

    // memories
    logic [3:0] wall_mem [CELLS];
    logic [7:0] dist_mem [CELLS];
    logic [7:0] queue_mem [QUEUE_DEPTH];

    logic [3:0] wall_rdata_reg;
    logic [7:0] dist_rdata_reg;
    logic [7:0] queue_rdata_reg;

    logic          wall_we, dist_we, queue_we;
    logic [CW-1:0] wall_wa, wall_ra, dist_wa, dist_ra;
    logic [3:0]    wall_wd;
    logic [7:0]    dist_wd, queue_wd;
    logic [QW-1:0] queue_wa, queue_ra;

    // control registers
    mffs_pkg::state_t state_reg, state_next;
    logic [3:0]    sr_reg, sr_next, sc_reg, sc_next;
    logic [QW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [3:0]    grl_reg, grl_next, grh_reg, grh_next;
    logic [3:0]    gcl_reg, gcl_next, gch_reg, gch_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic [2:0] op_reg, op_next;
    logic [3:0] row_reg, row_next, col_reg, col_next;
    logic [1:0] dir_reg, dir_next;
    logic       present_reg, present_next, goal_sel_reg, goal_sel_next;
    logic [7:0] din_reg, din_next;
    logic [3:0] cur_r_reg, cur_r_next, cur_c_reg, cur_c_next;
    logic [3:0] nb_r_reg, nb_r_next, nb_c_reg, nb_c_next;
    logic [1:0] nb_dir_reg, nb_dir_next;
    logic [7:0] cur_d_reg, cur_d_next;
    logic [3:0] cur_wall_reg, cur_wall_next;
    logic [7:0] low_dist_reg, low_dist_next;
    logic [7:0] res_dist_reg, res_dist_next;
    logic [3:0] res_wall_reg, res_wall_next;
    logic [1:0] res_dir_reg, res_dir_next;
    logic       res_done_reg, res_done_next;
    logic [mffs_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // helpers
    logic       on_grid, sweep_last, seed_on_grid;
    logic       nb_open;
    logic [3:0] nb_r, nb_c;
    logic       wnb_ok;
    logic [3:0] wnb_r, wnb_c;
    logic [3:0] wall_bit, wall_bit_opp, boundary;
    logic       enq;
    logic [7:0] enq_data;
    logic [7:0] cur_d_inc;

    assign s_tready = (state_reg == mffs_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign on_grid      = ({1'b0, row_reg} < SIDE5) && ({1'b0, col_reg} < SIDE5);
    assign seed_on_grid = ({1'b0, sr_reg} < SIDE5) && ({1'b0, sc_reg} < SIDE5);
    assign sweep_last   = (sr_reg == LAST) && (sc_reg == LAST);
    assign wall_bit     = 4'b0001 << dir_reg;
    assign wall_bit_opp = 4'b0001 << (dir_reg + 2'd2);
    assign cur_d_inc    = cur_d_reg + 8'd1;

    assign boundary = ((sr_reg == 4'd0) ? mffs_pkg::WALL_N : 4'h0)
                    | ((sc_reg == LAST) ? mffs_pkg::WALL_E : 4'h0)
                    | ((sr_reg == LAST) ? mffs_pkg::WALL_S : 4'h0)
                    | ((sc_reg == 4'd0) ? mffs_pkg::WALL_W : 4'h0);

    // neighbour of the current cell on side nb_dir, open when unwalled and on the grid
    always_comb
    begin
        nb_r    = cur_r_reg;
        nb_c    = cur_c_reg;
        nb_open = 1'b0;
        case (nb_dir_reg)
            mffs_pkg::DIR_N:
            begin
                nb_r    = cur_r_reg - 4'd1;
                nb_open = (cur_r_reg != 4'd0);
            end
            mffs_pkg::DIR_E:
            begin
                nb_c    = cur_c_reg + 4'd1;
                nb_open = (cur_c_reg != LAST);
            end
            mffs_pkg::DIR_S:
            begin
                nb_r    = cur_r_reg + 4'd1;
                nb_open = (cur_r_reg != LAST);
            end
            default:
            begin
                nb_c    = cur_c_reg - 4'd1;
                nb_open = (cur_c_reg != 4'd0);
            end
        endcase
        nb_open = nb_open && !cur_wall_reg[nb_dir_reg];
    end

    // neighbour across the wall being set or cleared
    always_comb
    begin
        wnb_r  = row_reg;
        wnb_c  = col_reg;
        wnb_ok = 1'b0;
        case (dir_reg)
            mffs_pkg::DIR_N:
            begin
                wnb_r  = row_reg - 4'd1;
                wnb_ok = (row_reg != 4'd0);
            end
            mffs_pkg::DIR_E:
            begin
                wnb_c  = col_reg + 4'd1;
                wnb_ok = (col_reg != LAST);
            end
            mffs_pkg::DIR_S:
            begin
                wnb_r  = row_reg + 4'd1;
                wnb_ok = (row_reg != LAST);
            end
            default:
            begin
                wnb_c  = col_reg - 4'd1;
                wnb_ok = (col_reg != 4'd0);
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        sr_next        = sr_reg;
        sc_next        = sc_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        grl_next       = grl_reg;
        grh_next       = grh_reg;
        gcl_next       = gcl_reg;
        gch_next       = gch_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        dir_next       = dir_reg;
        present_next   = present_reg;
        goal_sel_next  = goal_sel_reg;
        din_next       = din_reg;
        cur_r_next     = cur_r_reg;
        cur_c_next     = cur_c_reg;
        nb_r_next      = nb_r_reg;
        nb_c_next      = nb_c_reg;
        nb_dir_next    = nb_dir_reg;
        cur_d_next     = cur_d_reg;
        cur_wall_next  = cur_wall_reg;
        low_dist_next  = low_dist_reg;
        res_dist_next  = res_dist_reg;
        res_wall_next  = res_wall_reg;
        res_dir_next   = res_dir_reg;
        res_done_next  = res_done_reg;
        out_data_next  = out_data_reg;

        wall_we  = 1'b0;
        wall_wa  = cell_idx(sr_reg, sc_reg);
        wall_wd  = boundary;
        wall_ra  = cell_idx(row_reg, col_reg);
        dist_we  = 1'b0;
        dist_wa  = cell_idx(sr_reg, sc_reg);
        dist_wd  = mffs_pkg::DIST_NONE;
        dist_ra  = cell_idx(row_reg, col_reg);
        enq      = 1'b0;
        enq_data = {sr_reg, sc_reg};
        queue_ra = head_reg;

        // goal registers
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                mffs_pkg::REG_GOAL_ROW_LO: grl_next = cfg_wdata;
                mffs_pkg::REG_GOAL_ROW_HI: grh_next = cfg_wdata;
                mffs_pkg::REG_GOAL_COL_LO: gcl_next = cfg_wdata;
                default:                   gch_next = cfg_wdata;
            endcase
        end

        if (m_tready && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // clearing pass after reset, init op and flood clear share the sweep
            mffs_pkg::S_CLEAR, mffs_pkg::S_INIT, mffs_pkg::S_FCLR:
            begin
                wall_we = (state_reg != mffs_pkg::S_FCLR);
                dist_we = 1'b1;
                if (sc_reg == LAST)
                begin
                    sc_next = 4'd0;
                    sr_next = sr_reg + 4'd1;
                end
                else
                begin
                    sc_next = sc_reg + 4'd1;
                end
                if (sweep_last)
                begin
                    sr_next = 4'd0;
                    sc_next = 4'd0;
                    case (state_reg)
                        mffs_pkg::S_CLEAR: state_next = mffs_pkg::S_IDLE;
                        mffs_pkg::S_INIT:  state_next = mffs_pkg::S_DONE;
                        default:
                        begin
                            head_next = '0;
                            tail_next = '0;
                            fill_next = '0;
                            if (goal_sel_reg)
                            begin
                                sr_next = grl_reg;
                                sc_next = gcl_reg;
                                if (grl_reg > grh_reg || gcl_reg > gch_reg)
                                begin
                                    state_next = mffs_pkg::S_POP;
                                end
                                else
                                begin
                                    state_next = mffs_pkg::S_SEED;
                                end
                            end
                            else
                            begin
                                state_next = mffs_pkg::S_SEED;
                            end
                        end
                    endcase
                end
            end

            mffs_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next       = s_tuser;
                    row_next      = s_tdata[3:0];
                    col_next      = s_tdata[7:4];
                    dir_next      = s_tdata[9:8];
                    present_next  = s_tdata[10];
                    goal_sel_next = s_tdata[11];
                    din_next      = s_tdata[19:12];
                    state_next    = mffs_pkg::S_START;
                end
            end

            mffs_pkg::S_START:
            begin
                res_dist_next = 8'd0;
                res_wall_next = 4'd0;
                res_dir_next  = mffs_pkg::DIR_N;
                res_done_next = (op_reg <= mffs_pkg::OP_BEST);
                cur_r_next    = row_reg;
                cur_c_next    = col_reg;
                sr_next       = 4'd0;
                sc_next       = 4'd0;
                case (op_reg)
                    mffs_pkg::OP_INIT:  state_next = mffs_pkg::S_INIT;
                    mffs_pkg::OP_WALL:  state_next = on_grid ? mffs_pkg::S_WCELL
                                                             : mffs_pkg::S_DONE;
                    mffs_pkg::OP_FLOOD: state_next = mffs_pkg::S_FCLR;
                    mffs_pkg::OP_READ:
                    begin
                        if (on_grid)
                        begin
                            state_next = mffs_pkg::S_RCELL;
                        end
                        else
                        begin
                            res_dist_next = mffs_pkg::DIST_NONE;
                            res_wall_next = mffs_pkg::WALL_ALL;
                            state_next    = mffs_pkg::S_DONE;
                        end
                    end
                    mffs_pkg::OP_WRDIST:
                    begin
                        dist_we    = on_grid;
                        dist_wa    = cell_idx(row_reg, col_reg);
                        dist_wd    = din_reg;
                        state_next = mffs_pkg::S_DONE;
                    end
                    mffs_pkg::OP_BEST:  state_next = on_grid ? mffs_pkg::S_BCHK
                                                             : mffs_pkg::S_DONE;
                    default:            state_next = mffs_pkg::S_DONE;
                endcase
            end

            // wall change on the cell, then mirrored onto its neighbour when that lies on the grid
            mffs_pkg::S_WCELL:
            begin
                wall_we = 1'b1;
                wall_wa = cell_idx(row_reg, col_reg);
                wall_wd = present_reg ? (wall_rdata_reg | wall_bit)
                                      : (wall_rdata_reg & ~wall_bit);
                wall_ra = cell_idx(wnb_r, wnb_c);
                nb_r_next = wnb_r;
                nb_c_next = wnb_c;
                state_next = wnb_ok ? mffs_pkg::S_WNB : mffs_pkg::S_DONE;
            end

            mffs_pkg::S_WNB:
            begin
                wall_we = 1'b1;
                wall_wa = cell_idx(nb_r_reg, nb_c_reg);
                wall_wd = present_reg ? (wall_rdata_reg | wall_bit_opp)
                                      : (wall_rdata_reg & ~wall_bit_opp);
                state_next = mffs_pkg::S_DONE;
            end

            mffs_pkg::S_RCELL:
            begin
                res_dist_next = dist_rdata_reg;
                res_wall_next = wall_rdata_reg;
                state_next    = mffs_pkg::S_DONE;
            end

            // best direction: walk the four sides, strict less-than keeps the lowest side
            mffs_pkg::S_BCHK:
            begin
                cur_wall_next = wall_rdata_reg;
                nb_dir_next   = mffs_pkg::DIR_N;
                low_dist_next = mffs_pkg::DIST_NONE;
                state_next    = mffs_pkg::S_BNB;
            end

            mffs_pkg::S_BNB:
            begin
                dist_ra = cell_idx(nb_r, nb_c);
                if (nb_open)
                begin
                    state_next = mffs_pkg::S_BCMP;
                end
                else if (nb_dir_reg == mffs_pkg::DIR_W)
                begin
                    state_next = mffs_pkg::S_DONE;
                end
                else
                begin
                    nb_dir_next = nb_dir_reg + 2'd1;
                end
            end

            mffs_pkg::S_BCMP:
            begin
                if (dist_rdata_reg < low_dist_reg)
                begin
                    low_dist_next = dist_rdata_reg;
                    res_dir_next  = nb_dir_reg;
                end
                if (nb_dir_reg == mffs_pkg::DIR_W)
                begin
                    state_next = mffs_pkg::S_DONE;
                end
                else
                begin
                    nb_dir_next = nb_dir_reg + 2'd1;
                    state_next  = mffs_pkg::S_BNB;
                end
            end

            // seeding: one goal cell per cycle, or the start cell alone
            mffs_pkg::S_SEED:
            begin
                dist_we  = seed_on_grid;
                dist_wa  = cell_idx(sr_reg, sc_reg);
                dist_wd  = 8'd0;
                enq      = seed_on_grid;
                enq_data = {sr_reg, sc_reg};
                if (!goal_sel_reg || (sc_reg == gch_reg && sr_reg == grh_reg))
                begin
                    state_next = mffs_pkg::S_POP;
                end
                else if (sc_reg == gch_reg)
                begin
                    sc_next = gcl_reg;
                    sr_next = sr_reg + 4'd1;
                end
                else
                begin
                    sc_next = sc_reg + 4'd1;
                end
            end

            mffs_pkg::S_POP:
            begin
                if (fill_reg == '0)
                begin
                    state_next = mffs_pkg::S_DONE;
                end
                else
                begin
                    queue_ra   = head_reg;
                    head_next  = (head_reg == QLAST) ? '0 : head_reg + QW'(1);
                    fill_next  = fill_reg - FW'(1);
                    state_next = mffs_pkg::S_CELL;
                end
            end

            mffs_pkg::S_CELL:
            begin
                cur_r_next = queue_rdata_reg[7:4];
                cur_c_next = queue_rdata_reg[3:0];
                dist_ra    = cell_idx(queue_rdata_reg[7:4], queue_rdata_reg[3:0]);
                wall_ra    = cell_idx(queue_rdata_reg[7:4], queue_rdata_reg[3:0]);
                state_next = mffs_pkg::S_CHK;
            end

            mffs_pkg::S_CHK:
            begin
                cur_d_next    = dist_rdata_reg;
                cur_wall_next = wall_rdata_reg;
                nb_dir_next   = mffs_pkg::DIR_N;
                state_next    = (dist_rdata_reg == mffs_pkg::DIST_NONE) ? mffs_pkg::S_POP
                                                                        : mffs_pkg::S_NB;
            end

            mffs_pkg::S_NB:
            begin
                dist_ra   = cell_idx(nb_r, nb_c);
                nb_r_next = nb_r;
                nb_c_next = nb_c;
                if (nb_open)
                begin
                    state_next = mffs_pkg::S_UPD;
                end
                else if (nb_dir_reg == mffs_pkg::DIR_W)
                begin
                    state_next = mffs_pkg::S_POP;
                end
                else
                begin
                    nb_dir_next = nb_dir_reg + 2'd1;
                end
            end

            // relax the neighbour; its write lands before any later read of it
            mffs_pkg::S_UPD:
            begin
                if (dist_rdata_reg > cur_d_inc)
                begin
                    dist_we  = 1'b1;
                    dist_wa  = cell_idx(nb_r_reg, nb_c_reg);
                    dist_wd  = cur_d_inc;
                    enq      = 1'b1;
                    enq_data = {nb_r_reg, nb_c_reg};
                end
                if (nb_dir_reg == mffs_pkg::DIR_W)
                begin
                    state_next = mffs_pkg::S_POP;
                end
                else
                begin
                    nb_dir_next = nb_dir_reg + 2'd1;
                    state_next  = mffs_pkg::S_NB;
                end
            end

            // hand the result to the output register once it is free
            mffs_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, res_done_reg, res_dir_reg,
                                      res_wall_reg, res_dist_reg};
                    state_next     = mffs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mffs_pkg::S_IDLE;
            end
        endcase

        // ring append, dropped when full
        queue_we = enq && (fill_reg != QFULL);
        queue_wa = tail_reg;
        queue_wd = enq_data;
        if (queue_we)
        begin
            tail_next = (tail_reg == QLAST) ? '0 : tail_reg + QW'(1);
            fill_next = fill_reg + FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mffs_pkg::S_CLEAR;
            sr_reg        <= 4'd0;
            sc_reg        <= 4'd0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            grl_reg       <= 4'd7;
            grh_reg       <= 4'd8;
            gcl_reg       <= 4'd7;
            gch_reg       <= 4'd8;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sr_reg        <= sr_next;
            sc_reg        <= sc_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            grl_reg       <= grl_next;
            grh_reg       <= grh_next;
            gcl_reg       <= gcl_next;
            gch_reg       <= gch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        dir_reg      <= dir_next;
        present_reg  <= present_next;
        goal_sel_reg <= goal_sel_next;
        din_reg      <= din_next;
        cur_r_reg    <= cur_r_next;
        cur_c_reg    <= cur_c_next;
        nb_r_reg     <= nb_r_next;
        nb_c_reg     <= nb_c_next;
        nb_dir_reg   <= nb_dir_next;
        cur_d_reg    <= cur_d_next;
        cur_wall_reg <= cur_wall_next;
        low_dist_reg <= low_dist_next;
        res_dist_reg <= res_dist_next;
        res_wall_reg <= res_wall_next;
        res_dir_reg  <= res_dir_next;
        res_done_reg <= res_done_next;
        out_data_reg <= out_data_next;
    end

    // wall ram
    always_ff @(posedge clk)
    begin
        if (wall_we)
        begin
            wall_mem[wall_wa] <= wall_wd;
        end
        wall_rdata_reg <= wall_mem[wall_ra];
    end

    // distance ram
    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_wa] <= dist_wd;
        end
        dist_rdata_reg <= dist_mem[dist_ra];
    end

    // search ring, row in the high nibble
    always_ff @(posedge clk)
    begin
        if (queue_we)
        begin
            queue_mem[queue_wa] <= queue_wd;
        end
        queue_rdata_reg <= queue_mem[queue_ra];
    end

endmodule

// ===== rtl/mffs_checker.sv =====
`include "maze_flood_fill_solver_top_defines.svh"

module mffs_sva (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [mffs_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic [1:0] pend_reg, pend_next;
    logic       in_xfer, out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb
    begin
        pend_next = pend_reg + (in_xfer ? 2'd1 : 2'd0) - (out_xfer ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `MFFS_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `MFFS_ASSERT(a_no_extra, out_xfer |-> pend_reg != 2'd0, "result without a pending op")
    `MFFS_ASSERT(a_two_max, pend_reg == 2'd2 |-> !s_tready && pend_reg != 2'd3, "op taken with two results owed")
    `MFFS_ASSERT(a_undef_zero, m_tvalid && !m_tdata[mffs_pkg::OUT_DONE_BIT] |-> m_tdata[13:0] == 14'd0, "undefined op gave nonzero fields")
    `MFFS_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !m_tvalid, "result shown during reset")

endmodule

bind maze_flood_fill_solver_top mffs_sva u_mffs_sva (.*);
